/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// All assertions sample on i_clk and are masked while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AOTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AOTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/aots_pkg.sv */
// ----------------------------------------------------------------------------
// aots_pkg
// Types, constants and the trim mapping for the ADC offset trim search.
// ----------------------------------------------------------------------------
package aots_pkg;

    localparam int SAMPLE_W = 12;
    localparam int NIBBLE_W = 4;
    localparam int COUNT_W  = 8;
    localparam int CODE_W   = 6;
    localparam int SUM_W    = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET   = 8'd2;
    localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT_RESET = 8'd3;
    localparam logic [CODE_W-1:0]  TRIM_MAX        = 6'h3F;
    localparam logic [CODE_W-1:0]  TRIM_MIRROR     = 6'h1F;
    localparam logic [CODE_W-1:0]  TRIM_DIRECT_MIN = 6'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT   = 1'b0,
        REG_DEBOUNCE_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CODE_W-1:0] trim;
        logic              done;
    } t_cal_status;

    function automatic logic [CODE_W-1:0] trim_of(input logic [CODE_W-1:0] code);
        if (code >= TRIM_DIRECT_MIN) begin
            return code;
        end
        return TRIM_MIRROR - code;
    endfunction

endpackage

/* src/aots_core.sv */
// ----------------------------------------------------------------------------
// aots_core
// Calibration state: window counter, nibble accumulator, debounce counter,
// adjust code and done flag, with their single-pass update per sample.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aots_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [aots_pkg::NIBBLE_W-1:0]     i_nibble,
    input  logic [aots_pkg::COUNT_W-1:0]      i_sample_count,
    output aots_pkg::t_cal_status             o_next_status
);
    import aots_pkg::*;

    logic                r_done,     n_done;
    logic [COUNT_W-1:0]  r_window,   n_window;
    logic [COUNT_W-1:0]  r_debounce, n_debounce;
    logic [SUM_W-1:0]    r_sum,      n_sum;
    logic [CODE_W-1:0]   r_adjust,   n_adjust;
    logic [COUNT_W-1:0]  window_dec;
    logic [COUNT_W-1:0]  debounce_dec;
    logic [SUM_W-1:0]    threshold;

    assign window_dec   = r_window - 1'b1;
    assign debounce_dec = r_debounce - 1'b1;
    assign threshold    = SUM_W'(i_sample_count >> 1);

    always_comb begin
        n_done     = r_done;
        n_window   = r_window;
        n_debounce = r_debounce;
        n_sum      = r_sum;
        n_adjust   = r_adjust;
        if (!r_done) begin
            n_window = window_dec;
            if (window_dec == '0) begin
                n_window = i_sample_count;
                n_sum    = '0;
                if (r_sum > threshold) begin
                    n_debounce = debounce_dec;
                    if (debounce_dec == '0) begin
                        n_done = 1'b1;
                        if (r_adjust != '0) begin
                            n_adjust = r_adjust - 1'b1;
                        end
                    end
                end else if (trim_of(r_adjust) == TRIM_MAX) begin
                    n_done = 1'b1;
                end else begin
                    n_adjust = r_adjust + 1'b1;
                end
            end else begin
                n_sum = r_sum + SUM_W'(i_nibble);
            end
        end
    end

    assign o_next_status.trim = trim_of(n_adjust);
    assign o_next_status.done = n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= 1'b0;
            r_window   <= SAMPLE_COUNT_RESET;
            r_debounce <= DEBOUNCE_COUNT_RESET;
            r_sum      <= '0;
            r_adjust   <= '0;
        end else if (i_adv) begin
            r_done     <= n_done;
            r_window   <= n_window;
            r_debounce <= n_debounce;
            r_sum      <= n_sum;
            r_adjust   <= n_adjust;
        end
    end

    `AOTS_ASSERT_NEXT(a_done_sticky, r_done, r_done)
    `AOTS_ASSERT_NEXT(a_frozen_code, r_done, $stable(r_adjust))
    `AOTS_ASSERT_NEXT(a_sum_clear_on_close,
        i_adv && !r_done && r_window == 8'd1, r_sum == '0)

endmodule

/* src/adc_offset_trim_search.sv */
// ----------------------------------------------------------------------------
// adc_offset_trim_search
// ADC offset calibration sequencer: passes each conversion through and steps the
// offset trim code until the accumulated low nibbles settle or the trim hits its maximum.
// ----------------------------------------------------------------------------
// One request in, one result out: the whole update is counter and code steps,
// a 12-bit add and compares between the calibration state and the output
// register, so a new conversion is taken every cycle while the output register
// is empty or being drained in that cycle.
`include "assert_macros.svh"

module adc_offset_trim_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [aots_pkg::SAMPLE_W-1:0]     i_adc_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [aots_pkg::SAMPLE_W-1:0]     o_sample_value,
    output logic [aots_pkg::CODE_W-1:0]       o_trim_code,
    output logic                              o_cal_done,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aots_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aots_pkg::COUNT_W-1:0]      i_cfg_data
);
    import aots_pkg::*;

    logic [COUNT_W-1:0]  r_sample_count;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_sample;
    t_cal_status         r_status;
    t_cal_status         next_status;
    logic                in_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // debounce_count only matters at reset, where it is the reset constant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RESET;
        end else if (i_cfg_valid && t_cfg_reg'(i_cfg_index) == REG_SAMPLE_COUNT) begin
            r_sample_count <= i_cfg_data;
        end
    end

    aots_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (in_fire),
        .i_nibble       (i_adc_sample[NIBBLE_W-1:0]),
        .i_sample_count (r_sample_count),
        .o_next_status  (next_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample <= i_adc_sample;
            r_status <= next_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_sample;
    assign o_trim_code    = r_status.trim;
    assign o_cal_done     = r_status.done;

    `AOTS_ASSERT_NEXT(a_fire_loads_out, in_fire, r_out_valid)
    `AOTS_ASSERT_NOW(a_ready_when_empty, !r_out_valid, o_in_ready)
    `AOTS_ASSERT_NEXT(a_done_held_out,
        in_fire && r_out_valid && r_status.done, r_status.done)

endmodule
